// ----- rtl/core/pbpd_pkg.sv -----
// Shared types and constants for the per-band pulse descriptor builder.
// No dependencies; used by every module of the core.
package pbpd_pkg;

  localparam int unsigned BAND_W         = 6;
  localparam int unsigned FREQ_W         = 40;
  localparam int unsigned BAND_COUNT_W   = 7;
  localparam int unsigned LIMIT_W        = 11;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 64;

  localparam int unsigned NUM_BANDS_DEF  = 64;
  localparam int unsigned INDEX_BITS_DEF = 48;
  localparam int unsigned AMP_BITS_DEF   = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [BAND_COUNT_W-1:0] BAND_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAND  = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_FLUSH  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_COUNT  = 3'd0,
    CFG_THRESHOLD   = 3'd1,
    CFG_MAX_GAP     = 3'd2,
    CFG_MIN_SAMPLES = 3'd3,
    CFG_MAX_WIDTH   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [BAND_W-1:0]  band;
  } item_ctl_t;

endpackage

// ----- rtl/core/pbpd_front.sv -----
// Front end: takes input transfers, checks the band range, queues items.
// Depends on pbpd_pkg.
module pbpd_front import pbpd_pkg::*; #(
  parameter int unsigned NUM_BANDS  = NUM_BANDS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned AMP_BITS   = AMP_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic [BAND_W-1:0]       band_i,
  input  logic [INDEX_BITS-1:0]   sample_index_i,
  input  logic [AMP_BITS-1:0]     amplitude_i,
  input  logic [FREQ_W-1:0]       frequency_i,
  input  logic [BAND_COUNT_W-1:0] band_count_i,
  output logic                    q_valid_o,
  input  logic                    q_ready_i,
  output item_ctl_t               q_ctl_o,
  output logic [INDEX_BITS-1:0]   q_index_o,
  output logic [AMP_BITS-1:0]     q_amp_o,
  output logic [FREQ_W-1:0]       q_freq_o
);

  item_ctl_t             ctl_q  [2];
  logic [INDEX_BITS-1:0] idx_q  [2];
  logic [AMP_BITS-1:0]   amp_q  [2];
  logic [FREQ_W-1:0]     freq_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            cnt_q;
  logic                  push, pop;
  logic [LIMIT_W-1:0]    limit, band_ext;
  item_ctl_t             ctl_in;

  always_comb begin
    limit    = (band_count_i == '0) ? LIMIT_W'(NUM_BANDS) : LIMIT_W'(band_count_i);
    band_ext = LIMIT_W'(band_i);
    ctl_in.kind   = kind_e'(kind_i);
    ctl_in.band   = band_i;
    ctl_in.status = ((band_ext >= limit) || (band_ext >= LIMIT_W'(NUM_BANDS))) ? ST_BAND : ST_OK;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  assign q_ctl_o   = ctl_q[rd_ptr_q];
  assign q_index_o = idx_q[rd_ptr_q];
  assign q_amp_o   = amp_q[rd_ptr_q];
  assign q_freq_o  = freq_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wr_ptr_q]  <= ctl_in;
      idx_q[wr_ptr_q]  <= sample_index_i;
      amp_q[wr_ptr_q]  <= amplitude_i;
      freq_q[wr_ptr_q] <= frequency_i;
    end
  end

endmodule

// ----- rtl/core/pbpd_back.sv -----
// Back end: per-band state RAM with write bypass, pulse tracking, result register.
// Depends on pbpd_pkg.
module pbpd_back import pbpd_pkg::*; #(
  parameter int unsigned NUM_BANDS  = NUM_BANDS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned AMP_BITS   = AMP_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  item_ctl_t             q_ctl_i,
  input  logic [INDEX_BITS-1:0] q_index_i,
  input  logic [AMP_BITS-1:0]   q_amp_i,
  input  logic [FREQ_W-1:0]     q_freq_i,
  input  logic [AMP_BITS-1:0]   cfg_threshold_i,
  input  logic [INDEX_BITS-1:0] cfg_max_gap_i,
  input  logic [COUNT_BITS-1:0] cfg_min_samples_i,
  input  logic [INDEX_BITS-1:0] cfg_max_width_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic                  pulse_valid_o,
  output logic [BAND_W-1:0]     pulse_band_o,
  output logic [INDEX_BITS-1:0] pulse_start_o,
  output logic [INDEX_BITS-1:0] pulse_width_o,
  output logic [AMP_BITS-1:0]   peak_amplitude_o,
  output logic [FREQ_W-1:0]     peak_frequency_o,
  output logic [COUNT_BITS-1:0] pulse_samples_o,
  output logic                  pri_valid_o,
  output logic [INDEX_BITS-1:0] pri_samples_o
);

  localparam int unsigned AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  typedef struct packed {
    logic [INDEX_BITS-1:0] last;
    logic [INDEX_BITS-1:0] start;
    logic [INDEX_BITS-1:0] stop;
    logic [INDEX_BITS-1:0] seen_at;
    logic [AMP_BITS-1:0]   peak;
    logic [COUNT_BITS-1:0] cnt;
    logic [FREQ_W-1:0]     pfreq;
    logic [INDEX_BITS-1:0] prev;
  } rec_t;

  rec_t                  mem_q [NUM_BANDS];
  rec_t                  rd_q, fwd_q, rec, wr_rec;
  logic                  hit_q;
  logic [NUM_BANDS-1:0]  seen_q, open_q, kept_q;

  logic                  b_v_q;
  item_ctl_t             b_ctl_q;
  logic [INDEX_BITS-1:0] b_idx_q;
  logic [AMP_BITS-1:0]   b_amp_q;
  logic [FREQ_W-1:0]     b_freq_q;

  logic                  load, adv, wr_en;
  logic [AW-1:0]         rd_addr, ba;
  logic                  sv, op, pk;
  logic [COUNT_BITS-1:0] need;
  logic [INDEX_BITS-1:0] gmax, diff, width, gap;
  logic                  full, keep_ok, ooo, below, gap_ok;
  logic                  do_close, do_start, do_join, emit, state_ch;
  logic                  seen_n, open_n, kept_n;
  status_e               status;

  assign adv       = b_v_q && (!out_valid_o || out_ready_i);
  assign q_ready_o = !b_v_q || adv;
  assign load      = q_valid_i && q_ready_o;
  assign rd_addr   = AW'(q_ctl_i.band);
  assign ba        = AW'(b_ctl_q.band);
  assign wr_en     = adv && state_ch;

  assign rec = hit_q ? fwd_q : rd_q;
  assign sv  = seen_q[ba];
  assign op  = open_q[ba];
  assign pk  = kept_q[ba];

  always_comb begin
    need    = (cfg_min_samples_i == '0) ? COUNT_BITS'(1) : cfg_min_samples_i;
    gmax    = (cfg_max_gap_i == '0) ? INDEX_BITS'(1) : cfg_max_gap_i;
    diff    = rec.stop - rec.start;
    full    = &diff;
    width   = full ? diff : diff + INDEX_BITS'(1);
    keep_ok = (rec.cnt >= need) && (rec.stop >= rec.start) &&
              ((cfg_max_width_i == '0) || (!full && (width <= cfg_max_width_i)));
    ooo     = sv && (b_idx_q < rec.last);
    below   = $signed(b_amp_q) < $signed(cfg_threshold_i);
    gap     = (b_idx_q > rec.seen_at) ? b_idx_q - rec.seen_at : '0;
    gap_ok  = gap <= gmax;
  end

  always_comb begin
    status   = b_ctl_q.status;
    do_close = 1'b0;
    do_start = 1'b0;
    do_join  = 1'b0;
    state_ch = 1'b0;
    seen_n   = sv;
    if (b_ctl_q.status == ST_OK) begin
      if (b_ctl_q.kind == KIND_FLUSH) begin
        state_ch = 1'b1;
        do_close = op;
      end else if (ooo) begin
        status = ST_ORDER;
      end else begin
        state_ch = 1'b1;
        seen_n   = 1'b1;
        priority if (below) begin
          do_close = op;
        end else if (!op) begin
          do_start = 1'b1;
        end else if (gap_ok) begin
          do_join = 1'b1;
        end else begin
          do_close = 1'b1;
          do_start = 1'b1;
        end
      end
    end
    emit   = do_close && keep_ok;
    open_n = do_start ? 1'b1 : (do_close ? 1'b0 : op);
    kept_n = emit ? 1'b1 : pk;

    wr_rec = rec;
    if (b_ctl_q.kind == KIND_SAMPLE) wr_rec.last = b_idx_q;
    if (emit) wr_rec.prev = rec.start;
    if (do_start) begin
      wr_rec.start   = b_idx_q;
      wr_rec.stop    = b_idx_q;
      wr_rec.seen_at = b_idx_q;
      wr_rec.peak    = b_amp_q;
      wr_rec.cnt     = COUNT_BITS'(1);
      wr_rec.pfreq   = b_freq_q;
    end
    if (do_join) begin
      if (b_idx_q > rec.stop) wr_rec.stop = b_idx_q;
      wr_rec.seen_at = b_idx_q;
      if (~&rec.cnt) wr_rec.cnt = rec.cnt + COUNT_BITS'(1);
      if ($signed(b_amp_q) > $signed(rec.peak)) begin
        wr_rec.peak  = b_amp_q;
        wr_rec.pfreq = b_freq_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rd_q  <= mem_q[rd_addr];
      hit_q <= wr_en && (ba == rd_addr);
      fwd_q <= wr_rec;
    end
    if (wr_en) mem_q[ba] <= wr_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      open_q      <= '0;
      kept_q      <= '0;
      b_v_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (wr_en) begin
        seen_q[ba] <= seen_n;
        open_q[ba] <= open_n;
        kept_q[ba] <= kept_n;
      end
      if (load)     b_v_q <= 1'b1;
      else if (adv) b_v_q <= 1'b0;
      if (adv)              out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      b_ctl_q  <= q_ctl_i;
      b_idx_q  <= q_index_i;
      b_amp_q  <= q_amp_i;
      b_freq_q <= q_freq_i;
    end
    if (adv) begin
      status_o         <= status;
      pulse_valid_o    <= emit;
      pulse_band_o     <= emit ? b_ctl_q.band : '0;
      pulse_start_o    <= emit ? rec.start : '0;
      pulse_width_o    <= emit ? width : '0;
      peak_amplitude_o <= emit ? rec.peak : '0;
      peak_frequency_o <= emit ? rec.pfreq : '0;
      pulse_samples_o  <= emit ? rec.cnt : '0;
      pri_valid_o      <= emit && pk;
      pri_samples_o    <= (emit && pk) ? rec.start - rec.prev : '0;
    end
  end

endmodule

// ----- rtl/core/per_band_pulse_descriptor_builder_core.sv -----
// Top level of the per-band pulse descriptor builder: configuration registers,
// front end and back end. Depends on pbpd_pkg, pbpd_front, pbpd_back.
//
// One item is accepted per clock, sustained while the output is not held off,
// including back-to-back samples of the same band; every item yields one result,
// in order, via the queue, the state read and the result register. The rate is
// set by the per-band state RAM, which has one read and one write port: a
// state read and the write of the previous item happen in the same cycle, and a
// write-through bypass covers the same-band case. Per-band valid flags clear at
// reset at once, so no clearing pass is needed. Configuration is written with a
// one-cycle transfer and must only change while the block is idle.
module per_band_pulse_descriptor_builder_core import pbpd_pkg::*; #(
  parameter int unsigned NUM_BANDS  = NUM_BANDS_DEF,
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned AMP_BITS   = AMP_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [BAND_W-1:0]     band_i,
  input  logic [INDEX_BITS-1:0] sample_index_i,
  input  logic [AMP_BITS-1:0]   amplitude_i,
  input  logic [FREQ_W-1:0]     frequency_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic                  pulse_valid_o,
  output logic [BAND_W-1:0]     pulse_band_o,
  output logic [INDEX_BITS-1:0] pulse_start_o,
  output logic [INDEX_BITS-1:0] pulse_width_o,
  output logic [AMP_BITS-1:0]   peak_amplitude_o,
  output logic [FREQ_W-1:0]     peak_frequency_o,
  output logic [COUNT_BITS-1:0] pulse_samples_o,
  output logic                  pri_valid_o,
  output logic [INDEX_BITS-1:0] pri_samples_o
);

  logic [BAND_COUNT_W-1:0] band_count_q;
  logic [AMP_BITS-1:0]     threshold_q;
  logic [INDEX_BITS-1:0]   max_gap_q, max_width_q;
  logic [COUNT_BITS-1:0]   min_samples_q;

  logic                  q_valid, q_ready;
  item_ctl_t             q_ctl;
  logic [INDEX_BITS-1:0] q_index;
  logic [AMP_BITS-1:0]   q_amp;
  logic [FREQ_W-1:0]     q_freq;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q  <= BAND_COUNT_RST;
      threshold_q   <= '0;
      max_gap_q     <= INDEX_BITS'(1);
      min_samples_q <= COUNT_BITS'(1);
      max_width_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BAND_COUNT:  band_count_q  <= BAND_COUNT_W'(cfg_data_i);
        CFG_THRESHOLD:   threshold_q   <= AMP_BITS'(cfg_data_i);
        CFG_MAX_GAP:     max_gap_q     <= INDEX_BITS'(cfg_data_i);
        CFG_MIN_SAMPLES: min_samples_q <= COUNT_BITS'(cfg_data_i);
        CFG_MAX_WIDTH:   max_width_q   <= INDEX_BITS'(cfg_data_i);
        default: ;
      endcase
    end
  end

  pbpd_front #(
    .NUM_BANDS (NUM_BANDS),
    .INDEX_BITS(INDEX_BITS),
    .AMP_BITS  (AMP_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .band_i        (band_i),
    .sample_index_i(sample_index_i),
    .amplitude_i   (amplitude_i),
    .frequency_i   (frequency_i),
    .band_count_i  (band_count_q),
    .q_valid_o     (q_valid),
    .q_ready_i     (q_ready),
    .q_ctl_o       (q_ctl),
    .q_index_o     (q_index),
    .q_amp_o       (q_amp),
    .q_freq_o      (q_freq)
  );

  pbpd_back #(
    .NUM_BANDS (NUM_BANDS),
    .INDEX_BITS(INDEX_BITS),
    .AMP_BITS  (AMP_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_ready_o        (q_ready),
    .q_ctl_i          (q_ctl),
    .q_index_i        (q_index),
    .q_amp_i          (q_amp),
    .q_freq_i         (q_freq),
    .cfg_threshold_i  (threshold_q),
    .cfg_max_gap_i    (max_gap_q),
    .cfg_min_samples_i(min_samples_q),
    .cfg_max_width_i  (max_width_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .pulse_valid_o    (pulse_valid_o),
    .pulse_band_o     (pulse_band_o),
    .pulse_start_o    (pulse_start_o),
    .pulse_width_o    (pulse_width_o),
    .peak_amplitude_o (peak_amplitude_o),
    .peak_frequency_o (peak_frequency_o),
    .pulse_samples_o  (pulse_samples_o),
    .pri_valid_o      (pri_valid_o),
    .pri_samples_o    (pri_samples_o)
  );

`ifndef SYNTH
  // a rejected item never carries a pulse record
  a_reject_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> !pulse_valid_o)
    else $error("pulse record on rejected item");

  a_pri_needs_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pri_valid_o |-> pulse_valid_o)
    else $error("repetition interval without pulse");

  a_pulse_has_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pulse_valid_o |-> (pulse_samples_o != '0) && (pulse_width_o != '0))
    else $error("kept pulse with zero samples or width");
`endif

endmodule
